// ===== design/modular_vector_element_alu_macros.svh =====
// ----------------------------------------------------------------------------
// Modular vector element ALU assertion macros
// Wrappers for concurrent checks clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MODULAR_VECTOR_ELEMENT_ALU_MACROS_SVH
`define MODULAR_VECTOR_ELEMENT_ALU_MACROS_SVH

`ifndef SYNTHESIS
`define MVEA_ASSERT_IMP(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("check failed in same cycle");
`define MVEA_ASSERT_NXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("check failed in next cycle");
`else
`define MVEA_ASSERT_IMP(lbl, pre, post)
`define MVEA_ASSERT_NXT(lbl, pre, post)
`endif

`endif

// ===== design/mvea_pkg.sv =====
// ----------------------------------------------------------------------------
// Modular vector element ALU package
// Operation codes, register indexes and the stage control type.
// ----------------------------------------------------------------------------
package mvea_pkg;

    typedef enum logic [2:0] {
        MODE_ADD  = 3'd0,
        MODE_SUB  = 3'd1,
        MODE_MUL  = 3'd2,
        MODE_MAC  = 3'd3,
        MODE_SWMD = 3'd4,
        MODE_MOD2 = 3'd5
    } t_mode;

    typedef logic [0:0] t_cfg_idx;

    localparam t_cfg_idx CFG_MODULUS     = 1'b0;
    localparam t_cfg_idx CFG_NEW_MODULUS = 1'b1;

    typedef struct packed {
        logic  vld;
        t_mode mode;
    } t_ctl;

endpackage

// ===== design/mvea_reduce.sv =====
// ----------------------------------------------------------------------------
// Input reduction pipeline
// Reduces element, operand and scalar mod q and the modulus gap mod the new
// modulus, one remainder bit per stage.
// ----------------------------------------------------------------------------
module mvea_reduce #(
    parameter int W = 60
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  mvea_pkg::t_ctl  i_ctl,
    input  logic [W-1:0]    i_e,
    input  logic [W-1:0]    i_b,
    input  logic [W-1:0]    i_s,
    input  logic [W-1:0]    i_d,
    input  logic [W-1:0]    i_q,
    input  logic [W-1:0]    i_nq,
    output mvea_pkg::t_ctl  o_ctl,
    output logic [W-1:0]    o_e,
    output logic [W-1:0]    o_b,
    output logic [W-1:0]    o_s,
    output logic [W-1:0]    o_d
);
    import mvea_pkg::*;

    localparam int NL     = 4;
    localparam int LANE_D = 3;

    t_ctl         r_ctl [W];
    logic [W-1:0] r_rem [NL][W];
    logic [W-1:0] r_src [NL][W];

    t_ctl         w_ctl [W+1];
    logic [W-1:0] w_rem [NL][W+1];
    logic [W-1:0] w_src [NL][W+1];

    assign w_ctl[0]         = i_ctl;
    assign w_src[0][0]      = i_e;
    assign w_src[1][0]      = i_b;
    assign w_src[2][0]      = i_s;
    assign w_src[LANE_D][0] = i_d;

    for (genvar l = 0; l < NL; l++) begin : g_lane_tap
        assign w_rem[l][0] = '0;
        for (genvar k = 0; k < W; k++) begin : g_tap
            assign w_rem[l][k+1] = r_rem[l][k];
            assign w_src[l][k+1] = r_src[l][k];
        end
    end

    for (genvar k = 0; k < W; k++) begin : g_stage
        logic [W-1:0] n_rem [NL];
        logic [W-1:0] n_src [NL];

        assign w_ctl[k+1] = r_ctl[k];

        always_comb begin : p_step
            logic [W:0] cand;
            logic [W:0] modv;
            for (int l = 0; l < NL; l++) begin
                modv     = (l == LANE_D) ? {1'b0, i_nq} : {1'b0, i_q};
                cand     = {w_rem[l][k], w_src[l][k][W-1]};
                n_rem[l] = (cand >= modv) ? W'(cand - modv) : cand[W-1:0];
                n_src[l] = w_src[l][k] << 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[k].vld <= 1'b0;
            end else if (i_en) begin
                r_ctl[k].vld <= w_ctl[k].vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ctl[k].mode <= w_ctl[k].mode;
                for (int l = 0; l < NL; l++) begin
                    r_rem[l][k] <= n_rem[l];
                    r_src[l][k] <= n_src[l];
                end
            end
        end
    end

    assign o_ctl = w_ctl[W];
    assign o_e   = w_rem[0][W];
    assign o_b   = w_rem[1][W];
    assign o_s   = w_rem[2][W];
    assign o_d   = w_rem[LANE_D][W];

endmodule

// ===== design/mvea_mulmod.sv =====
// ----------------------------------------------------------------------------
// Modular multiplier pipeline
// Double-and-add multiplication mod q, one doubling or one addition per
// stage, with the element reduced mod the new modulus alongside.
// ----------------------------------------------------------------------------
module mvea_mulmod #(
    parameter int W = 60
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  mvea_pkg::t_ctl  i_ctl,
    input  logic [W-1:0]    i_e,
    input  logic [W-1:0]    i_b,
    input  logic [W-1:0]    i_s,
    input  logic [W-1:0]    i_dred,
    input  logic [W-1:0]    i_q,
    input  logic [W-1:0]    i_nq,
    output mvea_pkg::t_ctl  o_ctl,
    output logic [W-1:0]    o_e,
    output logic [W-1:0]    o_b,
    output logic [W-1:0]    o_dred,
    output logic [W-1:0]    o_prod,
    output logic [W-1:0]    o_enq
);
    import mvea_pkg::*;

    localparam int S = 2 * W;

    t_ctl         r_ctl  [S];
    logic [W-1:0] r_e    [S];
    logic [W-1:0] r_b    [S];
    logic [W-1:0] r_dred [S];
    logic [W-1:0] r_acc  [S];
    logic [W-1:0] r_a    [S];
    logic [W-1:0] r_m    [S];
    logic [W-1:0] r_nrem [S];
    logic [W-1:0] r_nsrc [S];

    t_ctl         w_ctl  [S+1];
    logic [W-1:0] w_e    [S+1];
    logic [W-1:0] w_b    [S+1];
    logic [W-1:0] w_dred [S+1];
    logic [W-1:0] w_acc  [S+1];
    logic [W-1:0] w_a    [S+1];
    logic [W-1:0] w_m    [S+1];
    logic [W-1:0] w_nrem [S+1];
    logic [W-1:0] w_nsrc [S+1];

    assign w_ctl[0]  = i_ctl;
    assign w_e[0]    = i_e;
    assign w_b[0]    = i_b;
    assign w_dred[0] = i_dred;
    assign w_acc[0]  = '0;
    assign w_a[0]    = (i_ctl.mode == MODE_MUL) ? i_e : i_b;
    assign w_m[0]    = (i_ctl.mode == MODE_MUL) ? i_b : i_s;
    assign w_nrem[0] = '0;
    assign w_nsrc[0] = i_e;

    for (genvar j = 0; j < S; j++) begin : g_stage
        logic [W-1:0] n_acc;
        logic [W-1:0] n_m;
        logic [W-1:0] n_nrem;
        logic [W-1:0] n_nsrc;

        assign w_ctl[j+1]  = r_ctl[j];
        assign w_e[j+1]    = r_e[j];
        assign w_b[j+1]    = r_b[j];
        assign w_dred[j+1] = r_dred[j];
        assign w_acc[j+1]  = r_acc[j];
        assign w_a[j+1]    = r_a[j];
        assign w_m[j+1]    = r_m[j];
        assign w_nrem[j+1] = r_nrem[j];
        assign w_nsrc[j+1] = r_nsrc[j];

        always_comb begin : p_mul
            logic [W:0] t;
            if ((j % 2) == 0) begin
                t   = {w_acc[j], 1'b0};
                n_m = w_m[j];
            end else begin
                t   = w_m[j][W-1] ? ({1'b0, w_acc[j]} + {1'b0, w_a[j]})
                                  : {1'b0, w_acc[j]};
                n_m = w_m[j] << 1;
            end
            n_acc = (t >= {1'b0, i_q}) ? W'(t - {1'b0, i_q}) : t[W-1:0];
        end

        always_comb begin : p_nred
            logic [W:0] cand;
            cand = {w_nrem[j], w_nsrc[j][W-1]};
            if (j < W) begin
                n_nrem = (cand >= {1'b0, i_nq}) ? W'(cand - {1'b0, i_nq})
                                                : cand[W-1:0];
                n_nsrc = w_nsrc[j] << 1;
            end else begin
                n_nrem = w_nrem[j];
                n_nsrc = w_nsrc[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[j].vld <= 1'b0;
            end else if (i_en) begin
                r_ctl[j].vld <= w_ctl[j].vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ctl[j].mode <= w_ctl[j].mode;
                r_e[j]        <= w_e[j];
                r_b[j]        <= w_b[j];
                r_dred[j]     <= w_dred[j];
                r_acc[j]      <= n_acc;
                r_a[j]        <= w_a[j];
                r_m[j]        <= n_m;
                r_nrem[j]     <= n_nrem;
                r_nsrc[j]     <= n_nsrc;
            end
        end
    end

    assign o_ctl  = w_ctl[S];
    assign o_e    = w_e[S];
    assign o_b    = w_b[S];
    assign o_dred = w_dred[S];
    assign o_prod = w_acc[S];
    assign o_enq  = w_nrem[S];

endmodule

// ===== design/mvea_result.sv =====
// ----------------------------------------------------------------------------
// Result stage
// Selects and finishes the result of each mode into the output register.
// ----------------------------------------------------------------------------
module mvea_result #(
    parameter int W = 60
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  mvea_pkg::t_ctl  i_ctl,
    input  logic [W-1:0]    i_e,
    input  logic [W-1:0]    i_b,
    input  logic [W-1:0]    i_dred,
    input  logic [W-1:0]    i_prod,
    input  logic [W-1:0]    i_enq,
    input  logic [W-1:0]    i_d,
    input  logic [W-1:0]    i_q,
    input  logic [W-1:0]    i_nq,
    output logic            o_vld,
    output logic [W-1:0]    o_value
);
    import mvea_pkg::*;

    logic         r_vld;
    logic [W-1:0] r_value;
    logic [W-1:0] n_value;

    function automatic logic [W-1:0] add_mod(input logic [W-1:0] a, input logic [W-1:0] b,
                                              input logic [W-1:0] m);
        logic [W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s >= {1'b0, m}) ? W'(s - {1'b0, m}) : s[W-1:0];
    endfunction

    function automatic logic [W-1:0] sub_mod(input logic [W-1:0] a, input logic [W-1:0] b,
                                              input logic [W-1:0] m);
        return (a >= b) ? (a - b) : (a + (m - b));
    endfunction

    always_comb begin
        logic         upper;
        upper = i_e > (i_q >> 1);
        case (i_ctl.mode)
            MODE_ADD:  n_value = add_mod(i_e, i_b, i_q);
            MODE_SUB:  n_value = sub_mod(i_e, i_b, i_q);
            MODE_MUL:  n_value = i_prod;
            MODE_MAC:  n_value = add_mod(i_e, i_prod, i_q);
            MODE_SWMD: begin
                if (i_nq > i_q) begin
                    n_value = upper ? (i_e + i_d) : i_e;
                end else begin
                    n_value = sub_mod(i_enq, upper ? i_dred : '0, i_nq);
                end
            end
            MODE_MOD2: n_value = {{(W-1){1'b0}}, i_e[0] ^ upper};
            default:   n_value = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_value <= n_value;
        end
    end

    assign o_vld   = r_vld;
    assign o_value = r_value;

endmodule

// ===== design/modular_vector_element_alu.sv =====
// ----------------------------------------------------------------------------
// Modular vector element ALU
// Modular add, subtract, multiply, multiply-accumulate, modulus switching and
// centered parity on one residue element per transfer.
// ----------------------------------------------------------------------------
// The slave stream carries element, operand and scalar in s_axis_tdata and
// the mode in s_axis_tuser; the master stream returns one value per input
// transfer, in order. The moduli must be written by the user through the
// plain register port while no item is in flight; the block does not enforce
// this. A modulus below two acts as two. The pipeline has ELEMENT_BITS
// remainder stages, 2*ELEMENT_BITS double-and-add stages of the modular
// multiplier and one output register. One transfer is taken every cycle
// while the pipeline advances. When the receiver stalls with a result
// waiting, the whole pipeline holds and s_axis_tready drops; nothing is lost
// or repeated. Reset clears all valid bits and sets both moduli to two.
// ----------------------------------------------------------------------------
`include "modular_vector_element_alu_macros.svh"

module modular_vector_element_alu #(
    parameter int ELEMENT_BITS = 60
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  mvea_pkg::t_cfg_idx                    i_cfg_idx,
    input  logic [ELEMENT_BITS-1:0]               i_cfg_data,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // element, operand, scalar, zero fill
    input  logic [((3*ELEMENT_BITS+7)/8)*8-1:0]   s_axis_tdata,
    // mode
    input  logic [2:0]                            s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // value, zero fill
    output logic [((ELEMENT_BITS+7)/8)*8-1:0]     m_axis_tdata
);
    import mvea_pkg::*;

    localparam int W      = ELEMENT_BITS;
    localparam int OUT_W  = ((W + 7) / 8) * 8;

    logic [W-1:0] r_modulus;
    logic [W-1:0] r_new_modulus;
    logic [W-1:0] q_eff;
    logic [W-1:0] nq_eff;
    logic [W-1:0] mod_gap;
    logic         advance;
    t_ctl         in_ctl;

    t_ctl         red_ctl;
    logic [W-1:0] red_e;
    logic [W-1:0] red_b;
    logic [W-1:0] red_s;
    logic [W-1:0] red_d;

    t_ctl         mul_ctl;
    logic [W-1:0] mul_e;
    logic [W-1:0] mul_b;
    logic [W-1:0] mul_dred;
    logic [W-1:0] mul_prod;
    logic [W-1:0] mul_enq;

    logic         out_vld;
    logic [W-1:0] out_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus     <= W'(2);
            r_new_modulus <= W'(2);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODULUS:     r_modulus     <= i_cfg_data;
                CFG_NEW_MODULUS: r_new_modulus <= i_cfg_data;
                default:         r_modulus     <= r_modulus;
            endcase
        end
    end

    assign q_eff   = (r_modulus < W'(2)) ? W'(2) : r_modulus;
    assign nq_eff  = (r_new_modulus < W'(2)) ? W'(2) : r_new_modulus;
    assign mod_gap = (q_eff > nq_eff) ? (q_eff - nq_eff) : (nq_eff - q_eff);

    assign advance       = !out_vld || m_axis_tready;
    assign s_axis_tready = advance;
    assign in_ctl.vld    = s_axis_tvalid;
    assign in_ctl.mode   = t_mode'(s_axis_tuser);

    mvea_reduce #(.W(W)) u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_ctl   (in_ctl),
        .i_e     (s_axis_tdata[W-1:0]),
        .i_b     (s_axis_tdata[2*W-1:W]),
        .i_s     (s_axis_tdata[3*W-1:2*W]),
        .i_d     (mod_gap),
        .i_q     (q_eff),
        .i_nq    (nq_eff),
        .o_ctl   (red_ctl),
        .o_e     (red_e),
        .o_b     (red_b),
        .o_s     (red_s),
        .o_d     (red_d)
    );

    mvea_mulmod #(.W(W)) u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_ctl   (red_ctl),
        .i_e     (red_e),
        .i_b     (red_b),
        .i_s     (red_s),
        .i_dred  (red_d),
        .i_q     (q_eff),
        .i_nq    (nq_eff),
        .o_ctl   (mul_ctl),
        .o_e     (mul_e),
        .o_b     (mul_b),
        .o_dred  (mul_dred),
        .o_prod  (mul_prod),
        .o_enq   (mul_enq)
    );

    mvea_result #(.W(W)) u_result (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_ctl   (mul_ctl),
        .i_e     (mul_e),
        .i_b     (mul_b),
        .i_dred  (mul_dred),
        .i_prod  (mul_prod),
        .i_enq   (mul_enq),
        .i_d     (mod_gap),
        .i_q     (q_eff),
        .i_nq    (nq_eff),
        .o_vld   (out_vld),
        .o_value (out_value)
    );

    assign m_axis_tvalid = out_vld;
    assign m_axis_tdata  = OUT_W'(out_value);

    `MVEA_ASSERT_IMP(a_reduced_below_q, red_ctl.vld, red_e < q_eff && red_b < q_eff)
    `MVEA_ASSERT_NXT(a_mod2_is_bit, mul_ctl.vld && advance && mul_ctl.mode == MODE_MOD2,
                     out_value <= W'(1))
    `MVEA_ASSERT_NXT(a_ring_result_below_q,
                     mul_ctl.vld && advance && (mul_ctl.mode == MODE_ADD ||
                     mul_ctl.mode == MODE_SUB || mul_ctl.mode == MODE_MUL ||
                     mul_ctl.mode == MODE_MAC),
                     out_value < q_eff)

endmodule
